// ===== hdl/dhfk_pkg.sv =====
// ============================================================================
// dhfk_pkg
// Types, constants and helpers for the D-H link chain unit.
// ============================================================================
`default_nettype none

package dhfk_pkg;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ANG_LOAD,
    ST_ANG_ITER,
    ST_ANG_DONE,
    ST_LINK_MUL,
    ST_LINK_WB,
    ST_MAT_MUL,
    ST_MAT_ACC,
    ST_MAT_FIN,
    ST_EMIT
  } dhfk_state_e;

  localparam int unsigned AtanSteps = 24;
  localparam int unsigned AtanIdxW  = 5;
  localparam int unsigned ZW        = 36;   // angle accumulator, Q30
  localparam int unsigned XW        = 34;   // rotation x/y, Q30

  localparam logic signed [ZW-1:0] PiQ30     = 36'sd3373259426;
  localparam logic signed [ZW-1:0] HalfPiQ30 = 36'sd1686629713;
  localparam logic signed [ZW-1:0] TwoPiQ30  = 36'sd6746518852;
  localparam logic signed [XW-1:0] GainQ30   = 34'sd652032874;
  localparam logic signed [31:0]   OneQ16    = 32'sd65536;

  // link entry indexes that take no multiply
  localparam logic [3:0] LkZero   = 4'd8;
  localparam logic [3:0] LkOffset = 4'd11;
  localparam logic [3:0] LastIdx  = 4'd11;

  // atan(2^-i) in Q30
  function automatic logic signed [31:0] atan_q30(input logic [AtanIdxW-1:0] i);
    logic signed [31:0] v;
    unique case (i)
      5'd0:  v = 32'sd843314857;
      5'd1:  v = 32'sd497837829;
      5'd2:  v = 32'sd263043837;
      5'd3:  v = 32'sd133525159;
      5'd4:  v = 32'sd67021687;
      5'd5:  v = 32'sd33543516;
      5'd6:  v = 32'sd16775851;
      5'd7:  v = 32'sd8388437;
      5'd8:  v = 32'sd4194283;
      5'd9:  v = 32'sd2097149;
      5'd10: v = 32'sd1048576;
      5'd11: v = 32'sd524288;
      5'd12: v = 32'sd262144;
      5'd13: v = 32'sd131072;
      5'd14: v = 32'sd65536;
      5'd15: v = 32'sd32768;
      5'd16: v = 32'sd16384;
      5'd17: v = 32'sd8192;
      5'd18: v = 32'sd4096;
      5'd19: v = 32'sd2048;
      5'd20: v = 32'sd1024;
      5'd21: v = 32'sd512;
      5'd22: v = 32'sd256;
      5'd23: v = 32'sd128;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

  // saturate a 64-bit value to 32-bit signed
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/dh_forward_kinematics_chain_unit.sv =====
// ============================================================================
// dh_forward_kinematics_chain_unit
// Chains D-H link transforms into a running 3x4 pose and streams it out.
// ============================================================================
// Usage:
//   Slave stream: one beat per link (theta, alpha, a, d). tuser = chain
//   start (pose goes back to identity before the link), tlast = chain end
//   (the pose is streamed out after the link is applied).
//   Master stream: on chain end, twelve beats in row order (row, column,
//   Q15.16 entry); tlast marks row 2 column 3.
//   Work: a link takes two passes through the one rotation (sine/cosine)
//   unit, each a load step, ITERATIONS rotation steps and a done step, then
//   12 link entries, each a multiply and a writeback on one shared 32x32
//   multiplier, then 12 pose entries of three multiply-accumulates and one
//   finishing step. With chain end, 12 output beats follow, one per
//   cycle while the receiver is ready. One link is handled at a time;
//   s_axis_tready_o is low from accept until the link (and its output) is done.
//   A receiver stall holds the current beat and the sequencer.
//   Reset: pose goes to identity, no output pending, input ready.
// ============================================================================
`default_nettype none

module dh_forward_kinematics_chain_unit #(
  parameter int ROTATION_ITERATIONS = 16,
  parameter int FRACTION_BITS       = 16
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // [17:0] joint_angle, [35:18] link_twist, [67:36] link_length,
  // [99:68] link_offset, [103:100] zero
  input  wire logic [103:0] s_axis_tdata_i,
  input  wire logic         s_axis_tuser_i,   // chain_start
  input  wire logic         s_axis_tlast_i,   // chain_end
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  // [1:0] row_index, [3:2] col_index, [35:4] entry_value, [39:36] zero
  output logic [39:0]       m_axis_tdata_o,
  output logic              m_axis_tlast_o    // final_entry
);

  localparam int ITERS = (ROTATION_ITERATIONS < int'(dhfk_pkg::AtanSteps)) ?
                         ROTATION_ITERATIONS : int'(dhfk_pkg::AtanSteps);
  localparam int TW    = FRACTION_BITS + 2;              // trig value width
  localparam int SH_TT = 2 * FRACTION_BITS - 16;         // trig*trig to Q16
  localparam int SH_AT = FRACTION_BITS;                  // a*trig to Q16
  localparam int SH_CR = 30 - FRACTION_BITS;             // Q30 to Q(F)
  localparam int XW    = int'(dhfk_pkg::XW);
  localparam int ZW    = int'(dhfk_pkg::ZW);

  localparam logic signed [TW-1:0] TrigOne = TW'(1) <<< FRACTION_BITS;
  localparam logic signed [XW-1:0] CrHalf  = XW'(1) <<< (SH_CR - 1);
  localparam logic [dhfk_pkg::AtanIdxW-1:0] IterLast = (dhfk_pkg::AtanIdxW)'(ITERS - 1);
  localparam logic [dhfk_pkg::AtanIdxW-1:0] IterOne  = (dhfk_pkg::AtanIdxW)'(1);

  dhfk_pkg::dhfk_state_e state_q, state_d;

  // stored link
  logic signed [17:0] theta_q, alpha_q;
  logic signed [31:0] len_q, off_q;
  logic               end_q;
  logic               ang_sel_q;   // 0: theta, 1: alpha

  // rotation unit
  logic signed [XW-1:0] x_q, y_q;
  logic signed [ZW-1:0] z_q;
  logic                 neg_q;
  logic [dhfk_pkg::AtanIdxW-1:0] it_q;
  logic signed [TW-1:0] st_q, ct_q, sa_q, ca_q;

  // multiply / accumulate
  logic signed [31:0] lk_q [12];
  logic signed [31:0] pose_q [12];
  logic signed [31:0] rowbuf_q [3];
  logic signed [63:0] prod_q, acc_q;
  logic [3:0] idx_q;     // link entry, pose entry {row,col}, or output beat
  logic [1:0] k_q;

  // ---------------------------------------------------------------------
  // angle reduction into [-pi/2, pi/2]
  logic signed [17:0]   ang_in;
  logic signed [ZW-1:0] z_raw, z_wrap, z_fold;
  logic                 fold_neg;

  always_comb begin
    ang_in   = ang_sel_q ? alpha_q : theta_q;
    z_raw    = {{(ZW-34){ang_in[17]}}, ang_in, 16'b0};
    if (z_raw > dhfk_pkg::PiQ30) z_wrap = z_raw - dhfk_pkg::TwoPiQ30;
    else if (z_raw < -dhfk_pkg::PiQ30) z_wrap = z_raw + dhfk_pkg::TwoPiQ30;
    else z_wrap = z_raw;
    fold_neg = 1'b1;
    if (z_wrap > dhfk_pkg::HalfPiQ30) z_fold = z_wrap - dhfk_pkg::PiQ30;
    else if (z_wrap < -dhfk_pkg::HalfPiQ30) z_fold = z_wrap + dhfk_pkg::PiQ30;
    else begin
      z_fold   = z_wrap;
      fold_neg = 1'b0;
    end
  end

  // one rotation step
  logic signed [XW-1:0] dx, dy, x_nx, y_nx;
  logic signed [ZW-1:0] z_nx, at_ext;

  always_comb begin
    dx     = y_q >>> it_q;
    dy     = x_q >>> it_q;
    at_ext = ZW'(dhfk_pkg::atan_q30(it_q));
    if (!z_q[ZW-1]) begin
      x_nx = x_q - dx;
      y_nx = y_q + dy;
      z_nx = z_q - at_ext;
    end else begin
      x_nx = x_q + dx;
      y_nx = y_q - dy;
      z_nx = z_q + at_ext;
    end
  end

  // rotation result: sign fold, round to Q(F), clamp
  logic signed [XW-1:0] xs, ys, xr, yr;
  logic signed [TW-1:0] cs_res, sn_res;

  always_comb begin
    xs = neg_q ? -x_q : x_q;
    ys = neg_q ? -y_q : y_q;
    xr = (xs + CrHalf) >>> SH_CR;
    yr = (ys + CrHalf) >>> SH_CR;
    if (xr > XW'(TrigOne)) cs_res = TrigOne;
    else if (xr < -XW'(TrigOne)) cs_res = -TrigOne;
    else cs_res = xr[TW-1:0];
    if (yr > XW'(TrigOne)) sn_res = TrigOne;
    else if (yr < -XW'(TrigOne)) sn_res = -TrigOne;
    else sn_res = yr[TW-1:0];
  end

  // ---------------------------------------------------------------------
  // shared multiplier operand select
  logic signed [31:0] op_a, op_b, pose_rd, lk_rd;
  logic signed [63:0] mul;
  logic [3:0]         pose_ra;
  logic               at_sel;   // link entry is a*trig

  always_comb begin
    unique case (state_q)
      dhfk_pkg::ST_EMIT:    pose_ra = idx_q;
      dhfk_pkg::ST_MAT_FIN: pose_ra = {idx_q[3:2], 2'd3};
      default:              pose_ra = {idx_q[3:2], k_q};
    endcase
    pose_rd = pose_q[pose_ra];
    lk_rd   = lk_q[{k_q, idx_q[1:0]}];
  end

  always_comb begin
    op_a   = 32'sd0;
    op_b   = 32'sd0;
    at_sel = 1'b0;
    if (state_q == dhfk_pkg::ST_MAT_MUL) begin
      op_a = pose_rd;
      op_b = lk_rd;
    end else begin
      unique case (idx_q)
        4'd0:  begin op_a = 32'(ct_q);  op_b = 32'(TrigOne); end
        4'd1:  begin op_a = -32'(st_q); op_b = 32'(ca_q); end
        4'd2:  begin op_a = 32'(st_q);  op_b = 32'(sa_q); end
        4'd3:  begin op_a = len_q;      op_b = 32'(ct_q); at_sel = 1'b1; end
        4'd4:  begin op_a = 32'(st_q);  op_b = 32'(TrigOne); end
        4'd5:  begin op_a = 32'(ct_q);  op_b = 32'(ca_q); end
        4'd6:  begin op_a = -32'(ct_q); op_b = 32'(sa_q); end
        4'd7:  begin op_a = len_q;      op_b = 32'(st_q); at_sel = 1'b1; end
        4'd9:  begin op_a = 32'(sa_q);  op_b = 32'(TrigOne); end
        4'd10: begin op_a = 32'(ca_q);  op_b = 32'(TrigOne); end
        default: begin op_a = 32'sd0;   op_b = 32'sd0; end
      endcase
    end
    mul = 64'(op_a) * 64'(op_b);
  end

  // link entry writeback value
  logic signed [63:0] lk_tt, lk_at;
  logic signed [31:0] lk_new;

  always_comb begin
    lk_tt = (prod_q + (64'sd1 <<< (SH_TT - 1))) >>> SH_TT;
    lk_at = (prod_q + (64'sd1 <<< (SH_AT - 1))) >>> SH_AT;
    if (idx_q == dhfk_pkg::LkZero) lk_new = 32'sd0;
    else if (idx_q == dhfk_pkg::LkOffset) lk_new = off_q;
    else lk_new = dhfk_pkg::sat32(at_sel ? lk_at : lk_tt);
  end

  // pose entry finish: add translation (column 3), round to Q16, saturate
  logic signed [63:0] fin_sum;
  logic signed [31:0] pose_new;

  always_comb begin
    fin_sum = acc_q;
    if (idx_q[1:0] == 2'd3) fin_sum = acc_q + (64'(pose_rd) <<< 14);
    pose_new = dhfk_pkg::sat32((fin_sum + 64'sd8192) >>> 14);
  end

  // ---------------------------------------------------------------------
  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dhfk_pkg::ST_IDLE:     if (s_axis_tvalid_i) state_d = dhfk_pkg::ST_ANG_LOAD;
      dhfk_pkg::ST_ANG_LOAD: state_d = dhfk_pkg::ST_ANG_ITER;
      dhfk_pkg::ST_ANG_ITER: if (it_q == IterLast) state_d = dhfk_pkg::ST_ANG_DONE;
      dhfk_pkg::ST_ANG_DONE:
        state_d = ang_sel_q ? dhfk_pkg::ST_LINK_MUL : dhfk_pkg::ST_ANG_LOAD;
      dhfk_pkg::ST_LINK_MUL: state_d = dhfk_pkg::ST_LINK_WB;
      dhfk_pkg::ST_LINK_WB:
        state_d = (idx_q == dhfk_pkg::LastIdx) ? dhfk_pkg::ST_MAT_MUL
                                               : dhfk_pkg::ST_LINK_MUL;
      dhfk_pkg::ST_MAT_MUL:  state_d = dhfk_pkg::ST_MAT_ACC;
      dhfk_pkg::ST_MAT_ACC:
        state_d = (k_q == 2'd2) ? dhfk_pkg::ST_MAT_FIN : dhfk_pkg::ST_MAT_MUL;
      dhfk_pkg::ST_MAT_FIN: begin
        if (idx_q != dhfk_pkg::LastIdx) state_d = dhfk_pkg::ST_MAT_MUL;
        else state_d = end_q ? dhfk_pkg::ST_EMIT : dhfk_pkg::ST_IDLE;
      end
      dhfk_pkg::ST_EMIT:
        if (m_axis_tready_i && idx_q == dhfk_pkg::LastIdx) state_d = dhfk_pkg::ST_IDLE;
      default: state_d = dhfk_pkg::ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    s_axis_tready_o = (state_q == dhfk_pkg::ST_IDLE);
    m_axis_tvalid_o = (state_q == dhfk_pkg::ST_EMIT);
    m_axis_tlast_o  = (state_q == dhfk_pkg::ST_EMIT) && (idx_q == dhfk_pkg::LastIdx);
    m_axis_tdata_o  = {4'b0, pose_rd, idx_q[1:0], idx_q[3:2]};
  end

  // ---------------------------------------------------------------------
  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= dhfk_pkg::ST_IDLE;
      ang_sel_q <= 1'b0;
      it_q      <= '0;
      idx_q     <= '0;
      k_q       <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        dhfk_pkg::ST_IDLE: begin
          ang_sel_q <= 1'b0;
          idx_q     <= '0;
          k_q       <= '0;
        end
        dhfk_pkg::ST_ANG_LOAD: it_q <= '0;
        dhfk_pkg::ST_ANG_ITER: it_q <= it_q + IterOne;
        dhfk_pkg::ST_ANG_DONE: ang_sel_q <= 1'b1;
        dhfk_pkg::ST_LINK_WB:  idx_q <= (idx_q == dhfk_pkg::LastIdx) ? 4'd0 : idx_q + 4'd1;
        dhfk_pkg::ST_MAT_ACC:  k_q <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
        dhfk_pkg::ST_MAT_FIN:  idx_q <= (idx_q == dhfk_pkg::LastIdx) ? 4'd0 : idx_q + 4'd1;
        dhfk_pkg::ST_EMIT:
          if (m_axis_tready_i) idx_q <= (idx_q == dhfk_pkg::LastIdx) ? 4'd0 : idx_q + 4'd1;
        default: ;
      endcase
    end
  end

  // pose matrix: identity at reset and on chain start
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < 12; j++)
        pose_q[j] <= (j == 0 || j == 5 || j == 10) ? dhfk_pkg::OneQ16 : 32'sd0;
    end else if (state_q == dhfk_pkg::ST_IDLE && s_axis_tvalid_i && s_axis_tuser_i) begin
      for (int j = 0; j < 12; j++)
        pose_q[j] <= (j == 0 || j == 5 || j == 10) ? dhfk_pkg::OneQ16 : 32'sd0;
    end else if (state_q == dhfk_pkg::ST_MAT_FIN && idx_q[1:0] == 2'd3) begin
      // commit a whole row once its last column is done
      pose_q[{idx_q[3:2], 2'd0}] <= rowbuf_q[0];
      pose_q[{idx_q[3:2], 2'd1}] <= rowbuf_q[1];
      pose_q[{idx_q[3:2], 2'd2}] <= rowbuf_q[2];
      pose_q[{idx_q[3:2], 2'd3}] <= pose_new;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      dhfk_pkg::ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          theta_q <= s_axis_tdata_i[17:0];
          alpha_q <= s_axis_tdata_i[35:18];
          len_q   <= s_axis_tdata_i[67:36];
          off_q   <= s_axis_tdata_i[99:68];
          end_q   <= s_axis_tlast_i;
        end
        acc_q <= '0;
      end
      dhfk_pkg::ST_ANG_LOAD: begin
        x_q   <= dhfk_pkg::GainQ30;
        y_q   <= '0;
        z_q   <= z_fold;
        neg_q <= fold_neg;
      end
      dhfk_pkg::ST_ANG_ITER: begin
        x_q <= x_nx;
        y_q <= y_nx;
        z_q <= z_nx;
      end
      dhfk_pkg::ST_ANG_DONE: begin
        if (ang_sel_q) begin
          sa_q <= sn_res;
          ca_q <= cs_res;
        end else begin
          st_q <= sn_res;
          ct_q <= cs_res;
        end
      end
      dhfk_pkg::ST_LINK_MUL: prod_q <= mul;
      dhfk_pkg::ST_LINK_WB:  lk_q[idx_q] <= lk_new;
      dhfk_pkg::ST_MAT_MUL:  prod_q <= mul;
      dhfk_pkg::ST_MAT_ACC:  acc_q <= acc_q + (prod_q >>> 2);
      dhfk_pkg::ST_MAT_FIN: begin
        if (idx_q[1:0] != 2'd3) rowbuf_q[idx_q[1:0]] <= pose_new;
        acc_q <= '0;
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  // last beat is always row 2, column 3
  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |-> m_axis_tdata_o[3:0] == 4'b1110)
    else $error("tlast on wrong entry");

  // one link at a time
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input taken while busy");

  // rotation counter stays in range
  a_iter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == dhfk_pkg::ST_ANG_ITER |-> it_q <= IterLast)
    else $error("rotation counter overrun");

  // no output while the input side is open
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(m_axis_tvalid_o && s_axis_tready_o))
    else $error("output and input overlap");
`endif

endmodule

`default_nettype wire

// ===== dv/tb_dh_forward_kinematics_chain_unit.sv =====
// ----------------------------------------------------------------------------
// tb_dh_forward_kinematics_chain_unit
// Drives link beats into the D-H chain unit, predicts each emitted pose from
// its own fixed-point model of the link transform and matrix product, and
// compares every output beat in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// pose predictor and expected-entry store
class pose_scoreboard;
  logic signed [31:0] pose[12];
  logic [39:0]        pending_entries[$];
  bit                 pending_last[$];
  int                 mismatch_cnt;

  function new();
    mismatch_cnt = 0;
    set_identity();
  endfunction

  function void set_identity();
    for (int k = 0; k < 12; k++) pose[k] = 0;
    pose[0] = 32'sd65536;
    pose[5] = 32'sd65536;
    pose[10] = 32'sd65536;
  endfunction

  static function longint asr(longint v, int s);
    return v >>> s;
  endfunction

  static function longint rnd_shift(longint v, int s);
    if (s == 0) return v;
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  static function longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // rotation-mode sine/cosine, Q16 results
  static function void trig(logic signed [17:0] ang, output longint sn, output longint cs);
    longint z, x, y, dx, dy, lim;
    bit     flip;
    z = longint'(ang) * 65536;
    x = 652032874;
    y = 0;
    lim = 65536;
    flip = 0;
    if (z > 64'sd3373259426) z -= 64'sd6746518852;
    else if (z < -64'sd3373259426) z += 64'sd6746518852;
    if (z > 64'sd1686629713) begin
      z -= 64'sd3373259426;
      flip = 1;
    end else if (z < -64'sd1686629713) begin
      z += 64'sd3373259426;
      flip = 1;
    end
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(dhfk_pkg::atan_q30(i[4:0]));
      end else begin
        x += dx; y -= dy; z += longint'(dhfk_pkg::atan_q30(i[4:0]));
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    x = rnd_shift(x, 14);
    y = rnd_shift(y, 14);
    cs = x > lim ? lim : (x < -lim ? -lim : x);
    sn = y > lim ? lim : (y < -lim ? -lim : y);
  endfunction

  // note an accepted link beat
  function void note_link(logic [103:0] data, bit start, bit chain_end);
    longint st, ct, sa, ca, a, d, acc;
    longint lk[12];
    longint nxt[12];
    if (start) set_identity();
    trig(data[17:0], st, ct);
    trig(data[35:18], sa, ca);
    a = longint'($signed(data[67:36]));
    d = longint'($signed(data[99:68]));
    lk[0] = clip32(ct);
    lk[1] = clip32(rnd_shift(-(st * ca), 16));
    lk[2] = clip32(rnd_shift(st * sa, 16));
    lk[3] = clip32(rnd_shift(a * ct, 16));
    lk[4] = clip32(st);
    lk[5] = clip32(rnd_shift(ct * ca, 16));
    lk[6] = clip32(rnd_shift(-(ct * sa), 16));
    lk[7] = clip32(rnd_shift(a * st, 16));
    lk[8] = 0;
    lk[9] = clip32(sa);
    lk[10] = clip32(ca);
    lk[11] = d;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 4; c++) begin
        acc = 0;
        for (int k = 0; k < 3; k++) acc += (longint'(pose[r*4+k]) * lk[k*4+c]) >>> 2;
        if (c == 3) acc += longint'(pose[r*4+3]) * 16384;
        nxt[r*4+c] = clip32(rnd_shift(acc, 14));
      end
    end
    for (int k = 0; k < 12; k++) pose[k] = nxt[k][31:0];
    if (chain_end) begin
      for (int k = 0; k < 12; k++) begin
        pending_entries.insert(pending_entries.size(),
                               {4'd0, pose[k], 2'(k % 4), 2'(k / 4)});
        pending_last.insert(pending_last.size(), k == 11);
      end
    end
  endfunction

  // check one output beat against the oldest expectation
  function void check_entry(logic [39:0] data, bit last);
    logic [39:0] exp_data;
    bit          exp_last;
    if (pending_entries.size() == 0) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10) $display("unexpected entry beat %h last %b", data, last);
      return;
    end
    exp_data = pending_entries.pop_front();
    exp_last = pending_last.pop_front();
    if (data[1:0] !== exp_data[1:0] || data[3:2] !== exp_data[3:2] ||
        data[35:4] !== exp_data[35:4] || data[39:36] !== 4'd0 || last !== exp_last) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10)
        $display({"entry mismatch: exp row %0d col %0d val %0d last %b, ",
                  "got row %0d col %0d val %0d last %b"},
                 exp_data[1:0], exp_data[3:2], $signed(exp_data[35:4]), exp_last,
                 data[1:0], data[3:2], $signed(data[35:4]), last);
    end
  endfunction
endclass

module tb_dh_forward_kinematics_chain_unit;
  localparam int CycleLimit = 400000;

  logic         clk_i = 0;
  logic         rst_ni = 0;
  logic         s_axis_tvalid_i = 0;
  logic         s_axis_tready_o;
  logic [103:0] s_axis_tdata_i = '0;
  logic         s_axis_tuser_i = 0;
  logic         s_axis_tlast_i = 0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 0;
  logic [39:0]  m_axis_tdata_o;
  logic         m_axis_tlast_o;

  pose_scoreboard pose_sb = new();
  int  cycle_cnt = 0;
  bit  rx_idle_on = 1;
  bit  tx_idle_on = 1;
  bit  rx_hold = 0;

  dh_forward_kinematics_chain_unit i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i), .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i(s_axis_tdata_i), .s_axis_tuser_i(s_axis_tuser_i),
    .s_axis_tlast_i(s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o), .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o(m_axis_tdata_o), .m_axis_tlast_o(m_axis_tlast_o)
  );

  always #2 clk_i = ~clk_i;

  // timeout
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver: random stalls, optional long hold-off
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) pose_sb.check_entry(m_axis_tdata_o, m_axis_tlast_o);
      m_axis_tready_i <= !rx_hold && !(rx_idle_on && $urandom_range(99) < 29);
    end
  end

  // one link beat, held until accepted
  task automatic send_link(logic signed [17:0] th, logic signed [17:0] al,
                           logic signed [31:0] len, logic signed [31:0] off,
                           bit start, bit chain_end);
    while (tx_idle_on && $urandom_range(99) < 29) @(posedge clk_i);
    s_axis_tvalid_i <= 1;
    s_axis_tdata_i <= {4'd0, off, len, al, th};
    s_axis_tuser_i <= start;
    s_axis_tlast_i <= chain_end;
    do @(posedge clk_i); while (!s_axis_tready_o);
    pose_sb.note_link({4'd0, off, len, al, th}, start, chain_end);
    s_axis_tvalid_i <= 0;
    // the unit is busy after an accept, so idling here costs nothing
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (pose_sb.pending_entries.size() != 0) @(posedge clk_i);
  endtask

  // random well-formed chain: start on the first link, end on the last
  task automatic send_random_chain(int n_links, bit wide);
    logic signed [31:0] len, off;
    for (int k = 0; k < n_links; k++) begin
      len = wide ? 32'($urandom) : 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      off = wide ? 32'($urandom) : 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      send_link(18'($urandom), 18'($urandom), len, off, k == 0, k == n_links - 1);
    end
  endtask

  initial begin
    int sent;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: identity link, field extremes, flags, wrap corners
    send_link(18'sd0, 18'sd0, 32'sd0, 32'sd0, 0, 1);
    send_link(18'sd51471, 18'sd0, 32'sd65536, 32'sd0, 0, 0);
    send_link(-18'sd51471, 18'sd25736, 32'sd131072, 32'sd65536, 0, 1);
    send_link(18'sd131071, -18'sd131072, 32'h7fffffff, 32'h80000000, 1, 1);
    send_link(-18'sd131072, 18'sd131071, 32'h80000000, 32'h7fffffff, 1, 0);
    send_link(18'sd25736, 18'sd25736, 32'h7fffffff, 32'h7fffffff, 0, 1);
    send_link(18'sd51472, -18'sd51472, -32'sd1, 32'sd1, 1, 0);
    send_link(18'sd25737, -18'sd25737, 32'sd3000000, -32'sd3000000, 0, 0);
    send_link(18'sd102944, -18'sd102944, 32'sd40000, 32'sd40000, 0, 1);
    send_link(18'sd102943, 18'sd77208, -32'sd65536, 32'sd0, 1, 1);
    send_link(-18'sd25736, -18'sd1, 32'h55555555, 32'haaaaaaaa, 0, 1);
    send_link(18'sd1, 18'sd0, 32'haaaaaaaa, 32'h55555555, 1, 1);

    // sender pause until all results are in
    wait_drained();
    repeat (20) @(posedge clk_i);

    // long receiver hold-off while links keep coming
    fork
      begin
        rx_hold = 1;
        repeat (1500) @(posedge clk_i);
        rx_hold = 0;
      end
      begin
        send_random_chain(4, 0);
        send_random_chain(3, 1);
      end
    join

    // random chains and occasional bare links, a stretch with no idling in the middle
    sent = 19;
    while (sent < 310) begin
      int n;
      tx_idle_on = !(sent > 120 && sent < 170);
      rx_idle_on = tx_idle_on;
      n = $urandom_range(1, 7);
      if ($urandom_range(9) == 0) begin
        send_link(18'($urandom), 18'($urandom), 32'($urandom), 32'($urandom),
                  1'($urandom), 1'($urandom));
        sent += 1;
      end else begin
        send_random_chain(n, $urandom_range(4) == 0);
        sent += n;
      end
    end
    tx_idle_on = 1;
    rx_idle_on = 1;

    wait_drained();
    repeat (300) @(posedge clk_i);
    if (pose_sb.mismatch_cnt == 0 && pose_sb.pending_entries.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

// ===== files.f =====
hdl/dhfk_pkg.sv
hdl/dh_forward_kinematics_chain_unit.sv
dv/tb_dh_forward_kinematics_chain_unit.sv
